// File: rtl/assert_macros.svh
// Assertion macros shared by the box filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every clock edge outside reset.
`define BFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BFM_ASSERT(lbl, prop, msg)
`define BFM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/bfm_pkg.sv
// Shared constants, types and helpers for the 3x3 box filter.
package bfm_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CMP_W   = 13;
  localparam int unsigned DIM_MIN = 3;

  // floor(x / 9) == (x * 3641) >> 15 for every x below 2^15 / 1
  localparam int unsigned   RECIP_SHIFT = 15;
  localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 12'd4;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } bfm_res_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned maxv);
    logic [CFG_W-1:0] res;
    if (CMP_W'(v) < CMP_W'(DIM_MIN)) begin
      res = CFG_W'(DIM_MIN);
    end else if (CMP_W'(v) > CMP_W'(maxv)) begin
      res = CFG_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: rtl/bfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfm_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/bfm_cfg.sv
// APB-style register file for image width and height.
module bfm_cfg import bfm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic [CFG_W-1:0] img_width,
  output logic [CFG_W-1:0] img_height,
  output logic             restart
);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic             wr_en;
  reg_idx_t         reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  width_nxt  = clamp_dim(pwdata[CFG_W-1:0], MAX_WIDTH);
        REG_HEIGHT: height_nxt = clamp_dim(pwdata[CFG_W-1:0], MAX_HEIGHT);
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_dim(CFG_W'(MAX_WIDTH_DEF), MAX_WIDTH);
      height_r <= clamp_dim(CFG_W'(MAX_HEIGHT_DEF), MAX_HEIGHT);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      default:    prdata = '0;
    endcase
  end

  // Any write restarts the frame
  assign restart    = wr_en;
  assign img_width  = width_r;
  assign img_height = height_r;

endmodule

// File: rtl/bfm_front.sv
// Raster counters, line store, window registers and 3x3 window sum.
module bfm_front import bfm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [CFG_W-1:0] img_width,
  input  logic [CFG_W-1:0] img_height,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  output logic             res_valid,
  input  logic             res_ready,
  output bfm_res_t         res
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [PIX_W-1:0] win_r [6];

  logic               accept;
  logic               s1_free;
  logic               s1_done;
  logic               s1_interior;
  logic [2*PIX_W-1:0] rows_rd;
  logic [PIX_W-1:0]   up1;
  logic [PIX_W-1:0]   up2;
  logic [CMP_W-1:0]   col_inc;
  logic [CMP_W-1:0]   row_inc;

  assign s1_interior = (s1_row_r >= ROW_W'(2)) && (s1_col_r >= COL_W'(2));
  assign s1_free     = !s1_valid_r || !s1_interior || res_ready;
  assign s1_done     = s1_valid_r && s1_free;
  assign in_ready    = s1_free;
  assign accept      = in_valid && s1_free;

  // Upper byte holds row r-2, lower byte row r-1
  bfm_ram #(
    .DATA_W (2 * PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_done),
    .wr_addr (s1_col_r),
    .wr_data ({up1, s1_pix_r}),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rows_rd)
  );

  assign up1 = rows_rd[PIX_W-1:0];
  assign up2 = rows_rd[2*PIX_W-1:PIX_W];

  // Advance the raster position, wrapping at row and frame ends; restart returns to row 0, column 0
  always_comb begin
    col_inc = CMP_W'(col_r) + CMP_W'(1);
    row_inc = CMP_W'(row_r) + CMP_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_inc >= CMP_W'(img_width)) begin
        col_nxt = '0;
        if (row_inc >= CMP_W'(img_height)) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_done) begin
        // Shift the window one column left
        win_r[3] <= win_r[0];
        win_r[4] <= win_r[1];
        win_r[5] <= win_r[2];
        win_r[0] <= up2;
        win_r[1] <= up1;
        win_r[2] <= s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  always_comb begin
    res.sum = SUM_W'(up2) + SUM_W'(up1) + SUM_W'(s1_pix_r)
            + SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
            + SUM_W'(win_r[3]) + SUM_W'(win_r[4]) + SUM_W'(win_r[5]);
    res.row  = COORD_W'(CMP_W'(s1_row_r) - CMP_W'(1));
    res.col  = COORD_W'(CMP_W'(s1_col_r) - CMP_W'(1));
    res.last = (CMP_W'(s1_row_r) == CMP_W'(img_height) - CMP_W'(1))
            && (CMP_W'(s1_col_r) == CMP_W'(img_width) - CMP_W'(1));
  end

  assign res_valid = s1_valid_r && s1_interior;

endmodule

// File: rtl/bfm_mean.sv
// Sum register, divide-by-nine with rounding, and result register.
module bfm_mean import bfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  bfm_res_t           res,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_mean_value,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               out_frame_last
);

  localparam int unsigned PROD_W = 2 * SUM_W;

  logic             s2_valid_r, s2_valid_nxt;
  bfm_res_t         s2_r;
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] mean_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic             last_r;

  logic              out_free;
  logic              s2_free;
  logic [SUM_W-1:0]  biased;
  logic [PROD_W-1:0] prod;

  assign out_free  = !out_valid_r || out_ready;
  assign s2_free   = !s2_valid_r || out_free;
  assign res_ready = s2_free;

  // (sum + 4) / 9 by reciprocal multiply
  assign biased = s2_r.sum + ROUND_BIAS;
  assign prod   = PROD_W'(biased) * PROD_W'(RECIP_NINE);

  always_comb begin
    s2_valid_nxt  = s2_valid_r;
    out_valid_nxt = out_valid_r;
    if (s2_free) begin
      s2_valid_nxt = res_valid;
    end
    if (out_free) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && res_valid) begin
      s2_r <= res;
    end
    if (out_free && s2_valid_r) begin
      mean_r <= prod[RECIP_SHIFT +: PIX_W];
      row_r  <= s2_r.row;
      col_r  <= s2_r.col;
      last_r <= s2_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_frame_last = last_r;

endmodule

// File: rtl/box_filter_3x3_mean.sv
// 3x3 box filter: one grayscale pixel per clock in raster order, one rounded mean per
// interior pixel out. The block sustains one pixel per clock unless a low out_ready backs
// up the pipeline and drops in_ready. A pixel passes the line store's registered read,
// taken at the accepting edge, then the window sum register and the divide-by-nine
// result register before its result is valid.
// The line store needs no clearing pass: border results are never produced, so entries
// not yet written are never used. Writing image_width (0x0) or image_height (0x4)
// restarts the frame at row 0, column 0; values are clamped to 3..MAX_WIDTH/MAX_HEIGHT.
`include "assert_macros.svh"

module box_filter_3x3_mean import bfm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   out_mean_value,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               out_frame_last
);

  logic [CFG_W-1:0] img_width;
  logic [CFG_W-1:0] img_height;
  logic             restart;
  logic             res_valid;
  logic             res_ready;
  bfm_res_t         res;

  assign pready = 1'b1;

  bfm_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .img_width  (img_width),
    .img_height (img_height),
    .restart    (restart)
  );

  bfm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .img_width  (img_width),
    .img_height (img_height),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel   (in_pixel),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  bfm_mean u_mean (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_value (out_mean_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

  // Input stalls only when every stage downstream is full and the output is held
  `BFM_ASSERT(a_stall_bp, !in_ready |-> (out_valid && !out_ready), "stall without backpressure")
  // A window sum waiting for the sum register must hold
  `BFM_ASSERT(a_sum_holds, (res_valid && !res_ready) |=> (res_valid && $stable(res)), "sum moved")
  // Reset empties the result register
  `BFM_ASSERT_ALWAYS(a_reset_clears_output, !rst_n |=> !out_valid, "result valid after reset")

endmodule

// File: test/box_mean_checker.sv
// Checker for the 3x3 box filter: follows config writes and pixels, predicts and compares means.
`timescale 1ns / 100ps

module box_mean_checker import bfm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PIX_W-1:0]   out_mean_value,
  input  logic [COORD_W-1:0] out_row,
  input  logic [COORD_W-1:0] out_col,
  input  logic               out_frame_last,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned LINE_W = MAX_WIDTH_DEF;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [PIX_W-1:0]   mean;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mean_res_t;

  mean_res_t        mean_q[$];
  logic [PIX_W-1:0] line_mem [2*LINE_W];
  logic [PIX_W-1:0] win [6];
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      img_w;
  int unsigned      img_h;
  int               fails;

  function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > maxv) return maxv;
    return v;
  endfunction

  always @(posedge clk) begin : track
    int unsigned ci;
    int unsigned up1;
    int unsigned up2;
    int unsigned total;
    mean_res_t   exp_r;
    mean_res_t   got_r;
    if (!rst_n) begin
      mean_q.delete();
      for (int k = 0; k < 6; k++) win[k] = '0;
      col_pos = 0;
      row_pos = 0;
      img_w = MAX_WIDTH_DEF;
      img_h = MAX_HEIGHT_DEF;
      fails = 0;
    end else begin
      // register write: new dimensions and a fresh frame, stores kept
      if (psel && penable && pwrite && pready) begin
        if (paddr[1:0] == 2'b00) begin
          if (reg_idx_t'(paddr[2]) == REG_WIDTH) begin
            img_w = fit_dim(pwdata[CFG_W-1:0], MAX_WIDTH_DEF);
          end else begin
            img_h = fit_dim(pwdata[CFG_W-1:0], MAX_HEIGHT_DEF);
          end
          col_pos = 0;
          row_pos = 0;
        end
      end

      if (in_valid && in_ready) begin
        ci = (col_pos < LINE_W) ? col_pos : 0;
        up1 = line_mem[ci];
        up2 = line_mem[LINE_W + ci];
        if (row_pos >= 2 && col_pos >= 2) begin
          total = up1 + up2 + in_pixel;
          for (int k = 0; k < 6; k++) total += win[k];
          exp_r.mean = PIX_W'((total + 4) / 9);
          exp_r.row  = COORD_W'(row_pos - 1);
          exp_r.col  = COORD_W'(col_pos - 1);
          exp_r.last = (row_pos == img_h - 1) && (col_pos == img_w - 1);
          mean_q.push_back(exp_r);
        end
        // age the line stores and shift the window one column
        line_mem[LINE_W + ci] = PIX_W'(up1);
        line_mem[ci] = in_pixel;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = PIX_W'(up2);
        win[1] = PIX_W'(up1);
        win[2] = in_pixel;
        col_pos++;
        if (col_pos >= img_w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= img_h) row_pos = 0;
        end
      end

      if (out_valid && out_ready) begin
        got_r.mean = out_mean_value;
        got_r.row  = out_row;
        got_r.col  = out_col;
        got_r.last = out_frame_last;
        if (mean_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: unexpected result mean %0d row %0d col %0d last %0b", $realtime,
                     got_r.mean, got_r.row, got_r.col, got_r.last);
        end else begin
          exp_r = mean_q.pop_front();
          if (got_r.mean !== exp_r.mean || got_r.row !== exp_r.row ||
              got_r.col !== exp_r.col || got_r.last !== exp_r.last) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("%0t: mismatch exp mean %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                       $realtime, exp_r.mean, exp_r.row, exp_r.col, exp_r.last,
                       got_r.mean, got_r.row, got_r.col, got_r.last);
          end
        end
      end
    end
    fail_count <= fails;
    pending <= mean_q.size();
  end

endmodule

// File: test/tb.sv
// Testbench top for the 3x3 box filter: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
  import bfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 250_000;
  localparam int unsigned DRAIN_CYCLES  = 6;
  localparam int unsigned RAND_ITEMS    = 1300;
  localparam int unsigned WIDE_ITEMS    = 40;
  localparam int unsigned STRETCH_ITEMS = 300;
  localparam int unsigned IDLE_PCT      = 36;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_mean_value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               out_frame_last;
  logic               gaps_on = 1'b1;
  int                 fail_count;
  int                 pending;
  int unsigned        cycles = 0;

  box_filter_3x3_mean dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_mean_value(out_mean_value),
    .out_row(out_row), .out_col(out_col), .out_frame_last(out_frame_last)
  );

  box_mean_checker mean_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_mean_value(out_mean_value),
    .out_row(out_row), .out_col(out_col), .out_frame_last(out_frame_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // valid is left high after acceptance; the next call replaces it in the same step
  task automatic push_pixel(input logic [PIX_W-1:0] p);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [31:0] wv, input logic [31:0] hv);
    wait_drained();
    reg_write(REG_WIDTH, wv);
    reg_write(REG_HEIGHT, hv);
  endtask

  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned n;
    int unsigned pause_at;
    int unsigned rand_items;
    int unsigned k;
    logic [31:0] wv;
    logic [31:0] hv;
    cur_w = DIM_MIN;
    cur_h = DIM_MIN;
    rand_items = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest frame, both dimensions written below the minimum
    set_dims(32'h0000_0000, 32'hFFFF_F802);
    repeat (9) push_pixel(8'hFF);
    // rounding: a sum of five rounds up to one, a sum of four down to zero
    for (k = 0; k < 9; k++) push_pixel((k == 0) ? 8'd5 : 8'd0);
    for (k = 0; k < 9; k++) push_pixel((k == 0) ? 8'd4 : 8'd0);
    push_pixel(8'hFF);
    push_pixel(8'h00);

    // widest row, width above the maximum; cut short by the next write
    set_dims(32'h0000_07FF, 32'hFFFF_F801);
    repeat (WIDE_ITEMS) push_pixel(pick_pixel());

    // tall frame, height written with high junk bits above the maximum; no idling
    gaps_on <= 1'b0;
    set_dims(32'h0000_0008, 32'h1234_07FF);
    repeat (STRETCH_ITEMS) push_pixel(pick_pixel());
    gaps_on <= 1'b1;

    while (rand_items < RAND_ITEMS) begin
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      wv = $urandom;
      hv = $urandom;
      wv[CFG_W-1:0] = CFG_W'(w);
      hv[CFG_W-1:0] = CFG_W'(h);
      if ($urandom_range(0, 9) == 0) begin
        wv[CFG_W-1:0] = CFG_W'($urandom_range(0, 2));
        w = DIM_MIN;
      end
      if ($urandom_range(0, 9) == 0) begin
        hv[CFG_W-1:0] = CFG_W'($urandom_range(0, 2));
        h = DIM_MIN;
      end
      wait_drained();
      case ((rand_items == 0) ? 2 : $urandom_range(0, 3))
        0: begin
          reg_write(REG_WIDTH, wv);
          cur_w = w;
        end
        1: begin
          reg_write(REG_HEIGHT, hv);
          cur_h = h;
        end
        default: begin
          reg_write(REG_HEIGHT, hv);
          reg_write(REG_WIDTH, wv);
          cur_w = w;
          cur_h = h;
        end
      endcase
      // whole frames, often followed by a partial one cut short by the next write
      n = cur_w * cur_h * $urandom_range(1, 2);
      if ($urandom_range(0, 1) == 1) n += $urandom_range(1, cur_w * cur_h - 1);
      pause_at = (rand_items == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : n;
      for (k = 0; k < n; k++) begin
        if (k == pause_at) wait_drained();
        push_pixel(pick_pixel());
      end
      rand_items += n;
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
